>>> design/pli_pkg.sv
// Package for the pixel palette indexer: palette depth, derived widths
// and the token that walks the chain of palette cells.
// No dependencies.
package pli_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int IDX_W = (PALETTE_DEPTH > 2) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

	typedef logic [23:0] color_t;

	typedef struct packed {
		logic             valid;
		color_t           color;
		logic [IDX_W-1:0] pos;
		logic [CNT_W-1:0] left;
		logic             hit;
		logic             fresh;
		logic [IDX_W-1:0] idx;
	} token_t;

endpackage

>>> design/pli_cell.sv
// One palette cell: holds one stored color and passes the lookup token
// on to the next cell every cycle.
// Depends on pli_pkg.
module pli_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  pli_pkg::token_t tok_i,
	output pli_pkg::token_t tok_o
);

	pli_pkg::color_t color_q;
	pli_pkg::token_t tok_q;
	pli_pkg::token_t tok_d;
	logic            live;
	logic            match;
	logic            append;

	assign live   = tok_i.valid && !tok_i.hit && !tok_i.fresh;
	assign match  = live && (tok_i.left != '0) && (color_q == tok_i.color);
	assign append = live && (tok_i.left == '0);

	always_comb begin
		tok_d       = tok_i;
		tok_d.pos   = tok_i.pos + 1'b1;
		tok_d.left  = (tok_i.left != '0) ? tok_i.left - 1'b1 : tok_i.left;
		tok_d.hit   = tok_i.hit | match;
		tok_d.fresh = tok_i.fresh | append;
		tok_d.idx   = (match || append) ? tok_i.pos : tok_i.idx;
	end

	// store the color where the palette ends
	always_ff @(posedge clk) begin
		if (append) begin
			color_q <= tok_i.color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_o = tok_q;

endmodule

>>> design/pli_chain.sv
// Row of palette cells, one per palette entry, linked head to tail.
// Depends on pli_pkg and pli_cell.
module pli_chain (
	input  logic            clk,
	input  logic            arst_n,
	input  pli_pkg::token_t tok_i,
	output pli_pkg::token_t tok_o
);

	pli_pkg::token_t link [pli_pkg::PALETTE_DEPTH+1];

	assign link[0] = tok_i;

	for (genvar g = 0; g < pli_pkg::PALETTE_DEPTH; g++) begin : g_cell
		pli_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.tok_i (link[g]),
			.tok_o (link[g+1])
		);
	end

	assign tok_o = link[pli_pkg::PALETTE_DEPTH];

endmodule

>>> design/pixel_palette_indexer_unit.sv
// Top level of the pixel palette indexer.
// Depends on pli_pkg and pli_chain.
//
// Usage: drive blue, green, red and raise start; the item is taken at a
// rising edge where start is high and busy is low. busy then stays high
// while the item walks the row of palette cells, one cell per cycle,
// comparing against each stored color and appending it at the first free
// cell. The result appears on color_index, new_color, palette_overflow,
// palette_size and bits_per_index for exactly one cycle with done high,
// registered from the token at the tail of the row. busy drops at the
// edge that loads the result, so a new item can be taken while the result
// is shown, but not while an earlier item is still walking through
// the cell row. The receiver cannot stall; results must be taken when
// done is high. Reset empties the palette at once (entry count to zero,
// no clearing pass) and drops busy and done; stored colors are only
// compared below the entry count.
module pixel_palette_indexer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] blue,
	input  logic [7:0] green,
	input  logic [7:0] red,
	output logic       done,
	output logic [7:0] color_index,
	output logic       new_color,
	output logic       palette_overflow,
	output logic [8:0] palette_size,
	output logic [3:0] bits_per_index
);

	pli_pkg::token_t          head;
	pli_pkg::token_t          tail;
	logic                     accept;
	logic                     busy_q;
	logic                     done_q;
	logic [pli_pkg::CNT_W-1:0] count_q;
	logic [pli_pkg::CNT_W-1:0] count_d;
	logic [pli_pkg::IDX_W+7:0] idx_ext;
	logic [pli_pkg::CNT_W+8:0] size_ext;
	logic [pli_pkg::CNT_W:0]   one_v;
	logic [3:0]               bits_d;
	logic [7:0]               color_index_q;
	logic                     new_color_q;
	logic                     overflow_q;
	logic [8:0]               size_q;
	logic [3:0]               bits_q;

	assign accept = start && !busy_q;

	always_comb begin
		head       = '0;
		head.valid = accept;
		head.color = {red, green, blue};
		head.left  = count_q;
	end

	pli_chain u_chain (
		.clk   (clk),
		.arst_n(arst_n),
		.tok_i (head),
		.tok_o (tail)
	);

	assign count_d  = tail.fresh ? count_q + 1'b1 : count_q;
	assign idx_ext  = {8'h00, tail.idx};
	assign size_ext = {9'h000, count_d};
	assign one_v    = {{pli_pkg::CNT_W{1'b0}}, 1'b1};

	always_comb begin
		bits_d = 4'd1;
		for (int b = 1; b < pli_pkg::CNT_W; b++) begin
			if ({1'b0, count_d} > (one_v << b)) begin
				bits_d = 4'(b + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= tail.valid;
			if (tail.valid) begin
				busy_q  <= 1'b0;
				count_q <= count_d;
			end else if (accept) begin
				busy_q <= 1'b1;
			end
		end
	end

	// hold the result fields for the strobe cycle
	always_ff @(posedge clk) begin
		if (tail.valid) begin
			color_index_q <= (tail.hit || tail.fresh) ? idx_ext[7:0] : 8'h00;
			new_color_q   <= tail.fresh;
			overflow_q    <= !tail.hit && !tail.fresh;
			size_q        <= size_ext[8:0];
			bits_q        <= bits_d;
		end
	end

	assign busy             = busy_q;
	assign done             = done_q;
	assign color_index      = color_index_q;
	assign new_color        = new_color_q;
	assign palette_overflow = overflow_q;
	assign palette_size     = size_q;
	assign bits_per_index   = bits_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("busy not raised after item accepted");

	a_tail_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> busy_q)
		else $error("token left chain while idle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, count_q} <= (pli_pkg::CNT_W+1)'(pli_pkg::PALETTE_DEPTH))
		else $error("entry count beyond palette depth");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(new_color_q && overflow_q))
		else $error("new color and overflow together");

	a_fresh_count: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid && tail.fresh |=> count_q == $past(count_q) + 1'b1)
		else $error("entry count not advanced on new color");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid && !tail.hit && !tail.fresh |->
			{1'b0, count_q} == (pli_pkg::CNT_W+1)'(pli_pkg::PALETTE_DEPTH))
		else $error("overflow with room left in palette");

endmodule

>>> tb/sv/tb.sv
// Testbench for pixel_palette_indexer_unit: directed and random pixels, a
// queue-fed driver, a monitor checked against an in-bench palette predictor.
// Depends on pli_pkg and the design sources.
`timescale 1ns / 100ps

module tb;

	localparam int RANDOM_ITEMS = 450;
	localparam int MAX_GAP      = 600;

	typedef struct {
		logic [7:0] color_index;
		logic       new_color;
		logic       palette_overflow;
		logic [8:0] palette_size;
		logic [3:0] bits_per_index;
	} palette_result_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       start  = 1'b0;
	logic [7:0] blue   = 8'h00;
	logic [7:0] green  = 8'h00;
	logic [7:0] red    = 8'h00;
	logic       busy;
	logic       done;
	logic [7:0] color_index;
	logic       new_color;
	logic       palette_overflow;
	logic [8:0] palette_size;
	logic [3:0] bits_per_index;

	pixel_palette_indexer_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.blue(blue), .green(green), .red(red),
		.done(done), .color_index(color_index), .new_color(new_color),
		.palette_overflow(palette_overflow), .palette_size(palette_size),
		.bits_per_index(bits_per_index)
	);

	pli_pkg::color_t pixel_q[$];
	pli_pkg::color_t seen_q[$];
	bit              seen_set[pli_pkg::color_t];
	palette_result_t result_q[$];

	pli_pkg::color_t pal_colors[pli_pkg::PALETTE_DEPTH];
	int              pal_count = 0;

	int n_items    = 0;
	int n_accepted = 0;
	int n_errors   = 0;
	int gap_left   = 0;
	int calm_left  = 0;
	longint cycles = 0;
	longint limit_cycles;

	function automatic palette_result_t lookup_pixel(pli_pkg::color_t c);
		palette_result_t res;
		int              idx;
		int              bits;
		int              span;
		idx = -1;
		for (int i = 0; i < pal_count; i++) begin
			if (idx < 0 && pal_colors[i] == c)
				idx = i;
		end
		res.new_color        = 1'b0;
		res.palette_overflow = 1'b0;
		if (idx >= 0) begin
			res.color_index = idx[7:0];
		end else if (pal_count < pli_pkg::PALETTE_DEPTH) begin
			pal_colors[pal_count] = c;
			res.color_index = pal_count[7:0];
			res.new_color   = 1'b1;
			pal_count++;
		end else begin
			res.color_index      = 8'd0;
			res.palette_overflow = 1'b1;
		end
		bits = 1;
		span = 2;
		while (span < pal_count) begin
			span = span << 1;
			bits++;
		end
		res.palette_size   = pal_count[8:0];
		res.bits_per_index = bits[3:0];
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(99);
		if (r < 4) begin
			calm_left = $urandom_range(30, 10);
			return 0;
		end
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(4, 1);
		if (r < 97) return $urandom_range(300, 5);
		return $urandom_range(MAX_GAP, 300);
	endfunction

	task automatic add_pixel(pli_pkg::color_t c);
		pixel_q = {pixel_q, c};
		if (!seen_set.exists(c)) begin
			seen_set[c] = 1'b1;
			seen_q = {seen_q, c};
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// driver: hold start until taken, then idle for a random gap
	always @(posedge clk or negedge arst_n) begin
		logic            nxt_start;
		pli_pkg::color_t nxt_pix;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			nxt_start = start;
			nxt_pix   = {red, green, blue};
			if (start && !busy) begin
				result_q = {result_q, lookup_pixel({red, green, blue})};
				n_accepted++;
				nxt_start = 1'b0;
				gap_left  = pick_gap();
			end
			if (!nxt_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pixel_q.size() > 0) begin
					nxt_pix   = pixel_q.pop_front();
					nxt_start = 1'b1;
				end
			end
			start <= nxt_start;
			{red, green, blue} <= nxt_pix;
		end
	end

	// monitor: every done cycle carries one result
	always @(posedge clk) begin
		palette_result_t want;
		if (arst_n && done) begin
			if (result_q.size() == 0) begin
				$error("result with no item pending: index %0d", color_index);
				n_errors++;
			end else begin
				want = result_q.pop_front();
				if (color_index !== want.color_index) begin
					$error("color_index: expected %0d, got %0d", want.color_index, color_index);
					n_errors++;
				end
				if (new_color !== want.new_color) begin
					$error("new_color: expected %0d, got %0d", want.new_color, new_color);
					n_errors++;
				end
				if (palette_overflow !== want.palette_overflow) begin
					$error("palette_overflow: expected %0d, got %0d",
						want.palette_overflow, palette_overflow);
					n_errors++;
				end
				if (palette_size !== want.palette_size) begin
					$error("palette_size: expected %0d, got %0d",
						want.palette_size, palette_size);
					n_errors++;
				end
				if (bits_per_index !== want.bits_per_index) begin
					$error("bits_per_index: expected %0d, got %0d",
						want.bits_per_index, bits_per_index);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= limit_cycles) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		pli_pkg::color_t c;
		int              r;
		limit_cycles = 3 * longint'(RANDOM_ITEMS + 40) *
			(pli_pkg::PALETTE_DEPTH + 4 + MAX_GAP) + 20000;

		add_pixel(24'h000000);
		add_pixel(24'h000000);
		add_pixel(24'hFFFFFF);
		add_pixel(24'hFF0000);
		add_pixel(24'h00FF00);
		add_pixel(24'h0000FF);
		add_pixel(24'h000001);
		add_pixel(24'h800000);
		add_pixel(24'h008000);
		add_pixel(24'h000080);
		add_pixel(24'hFFFFFE);
		add_pixel(24'h010203);
		add_pixel(24'h030201);
		add_pixel(24'h7F7F7F);
		add_pixel(24'h808080);
		add_pixel(24'hFFFFFF);
		add_pixel(24'h0000FF);
		add_pixel(24'h030201);
		add_pixel(24'h000000);
		add_pixel(24'h808080);

		// mostly fresh colors, the rest hits; fresh ones overflow once the palette fills
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			r = $urandom_range(99);
			if (r < 62) begin
				do begin
					if ($urandom_range(4) == 0)
						c = seen_q[$urandom_range(seen_q.size() - 1)] ^
							(24'h1 << $urandom_range(23));
					else
						c = 24'($urandom_range(24'hFFFFFF));
				end while (seen_set.exists(c));
			end else if (r < 70) begin
				c = seen_q[seen_q.size() - 1];
			end else begin
				c = seen_q[$urandom_range(seen_q.size() - 1)];
			end
			add_pixel(c);
		end
		n_items = pixel_q.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (n_accepted < n_items || result_q.size() != 0)
			@(posedge clk);
		repeat (pli_pkg::PALETTE_DEPTH + 16) @(posedge clk);

		if (n_errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
